[design/mbp_pkg.sv]
// Shared types and constants for the MSB-first bit packer.
`default_nettype none

package mbp_pkg;

    localparam int DATA_BITS = 64;
    localparam int MAX_BYTES = 8;
    localparam int Q_DEPTH   = 4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] code;
        logic [6:0]  width;
    } t_req;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [63:0] total_bits;
        logic [61:0] total_bytes;
    } t_rsp;

    // One burst of bytes: data left-aligned, nbytes in 1..8.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic [63:0] total_bits;
        logic [61:0] total_bytes;
    } t_rec;

    typedef struct packed {
        logic vld;
        t_rec rec;
    } t_push;

endpackage

`default_nettype wire

[design/msb_first_bit_packer.sv]
// Top level of the MSB-first variable-width bit packer.
//
//  channel   dir  handshake                 payload
//  request   in   i_in_valid / o_in_stall   i_in_req  (func, code, width)
//  result    out  o_out_valid / i_out_stall o_out_rsp (out_byte, last, totals)
//
// A request is registered, then applied to the accumulator; a new request can
// follow every cycle while the burst queue has room.
// A request that empties the accumulator queues one burst of 1..8 bytes; the result
// port sends one byte per cycle when not stalled, so byte-heavy streams run at the
// output rate. Requests stall only while the burst queue (four bursts) is full.
// Reset clears the accumulator, fill, bit total and the queue; no clearing pass.
`default_nettype none

module msb_first_bit_packer #(
    parameter int ACC_BITS = 64
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_stall,
    input  mbp_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output mbp_pkg::t_rsp o_out_rsp
);

    mbp_pkg::t_push push;
    logic           full;

    mbp_core #(
        .ACC_BITS (ACC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (i_in_req),
        .i_full  (full),
        .o_push  (push)
    );

    mbp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

[design/mbp_core.sv]
// Request register, accumulator update and burst generation.
`default_nettype none

module mbp_core #(
    parameter int ACC_BITS = 64
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  mbp_pkg::t_req  i_req,
    input  wire            i_full,
    output mbp_pkg::t_push o_push
);

    localparam int FW   = $clog2(ACC_BITS + 1);
    localparam int LW   = $clog2(ACC_BITS + 65);
    localparam int CW   = ACC_BITS + 64;
    localparam int MAXD = (ACC_BITS + 63) / ACC_BITS;
    localparam int NB   = (ACC_BITS + 7) / 8;
    localparam int DSH  = mbp_pkg::DATA_BITS - ACC_BITS;

    logic                r_in_vld;
    mbp_pkg::t_req       r_in;
    logic [ACC_BITS-1:0] r_acc;
    logic [FW-1:0]       r_fill;
    logic [63:0]         r_bt;

    logic [ACC_BITS-1:0] n_acc;
    logic [FW-1:0]       n_fill;
    logic [63:0]         n_bt;

    logic                proc;
    logic [6:0]          ws;
    logic [63:0]         code_m;
    logic [CW-1:0]       cat;
    logic [CW-1:0]       blk_w;
    logic [CW-1:0]       tail_w;
    logic [LW-1:0]       rem;
    logic                drained;
    logic [6:0]          fsh;
    mbp_pkg::t_push      push;

    assign proc    = r_in_vld && !i_full;
    assign o_stall = r_in_vld && i_full;

    always_comb begin
        ws     = (r_in.width > 7'd64) ? 7'd64 : r_in.width;
        code_m = r_in.code & ((64'd1 << ws) - 64'd1);
        cat    = (CW'(r_acc) << ws) | CW'(code_m);
        rem    = LW'(r_fill) + LW'(ws);
        drained = 1'b0;
        // each full accumulator passed on the way is drained; only the last one is kept
        for (int k = 0; k < MAXD; k++) begin
            if (rem > LW'(ACC_BITS)) begin
                rem     = rem - LW'(ACC_BITS);
                drained = 1'b1;
            end
        end
        blk_w  = cat >> rem;
        tail_w = cat & ((CW'(1) << rem) - CW'(1));
        fsh    = 7'd64 - 7'(r_fill);
    end

    always_comb begin
        n_acc  = r_acc;
        n_fill = r_fill;
        n_bt   = r_bt;
        push   = '0;
        if (proc) begin
            if (r_in.func == mbp_pkg::FUNC_FLUSH) begin
                n_acc                = '0;
                n_fill               = '0;
                push.vld             = (r_fill != '0);
                push.rec.data        = 64'(r_acc) << fsh;
                push.rec.nbytes      = 4'((8'(r_fill) + 8'd7) >> 3);
            end else begin
                n_acc                = tail_w[ACC_BITS-1:0];
                n_fill               = rem[FW-1:0];
                n_bt                 = r_bt + 64'(ws);
                push.vld             = drained;
                push.rec.data        = 64'(blk_w[ACC_BITS-1:0]) << DSH;
                push.rec.nbytes      = 4'(NB);
            end
        end
        push.rec.total_bits  = n_bt;
        push.rec.total_bytes = 62'(n_bt >> 3) + 62'(|n_bt[2:0]);
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_acc    <= '0;
            r_fill   <= '0;
            r_bt     <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            r_acc  <= n_acc;
            r_fill <= n_fill;
            r_bt   <= n_bt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_req;
        end
    end

endmodule

`default_nettype wire

[design/mbp_outq.sv]
// Burst queue and byte serializer for the result channel.
`default_nettype none

module mbp_outq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  mbp_pkg::t_push i_push,
    output logic           o_full,
    output logic           o_valid,
    input  wire            i_stall,
    output mbp_pkg::t_rsp  o_rsp
);

    localparam int AW = $clog2(mbp_pkg::Q_DEPTH);
    localparam int CNW = $clog2(mbp_pkg::Q_DEPTH + 1);

    mbp_pkg::t_rec r_mem [mbp_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CNW-1:0] r_cnt;
    logic [2:0]     r_bidx;

    mbp_pkg::t_rec  head;
    logic [63:0]    shifted;
    logic           take;
    logic           pop;
    logic           push;

    assign head    = r_mem[r_rp];
    assign o_full  = (r_cnt == CNW'(mbp_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign shifted = head.data << {r_bidx, 3'b000};

    always_comb begin
        o_rsp.out_byte    = shifted[63:56];
        o_rsp.last        = ((4'(r_bidx) + 4'd1) == head.nbytes);
        o_rsp.total_bits  = head.total_bits;
        o_rsp.total_bytes = head.total_bytes;
    end

    assign take = o_valid && !i_stall;
    assign pop  = take && o_rsp.last;
    assign push = i_push.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_bidx <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (pop) begin
                r_rp   <= r_rp + AW'(1);
                r_bidx <= '0;
            end else if (take) begin
                r_bidx <= r_bidx + 3'd1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.rec;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(mbp_pkg::Q_DEPTH))
        else $error("burst queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !push)
        else $error("burst written into full queue");

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (4'(r_bidx) < head.nbytes))
        else $error("byte index past end of burst");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_rsp.last) |=> (o_valid && r_bidx == $past(r_bidx) + 3'd1))
        else $error("burst cut short");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the MSB-first bit packer: random and directed requests.
`timescale 1ns / 1ps

module tb_top;

    localparam int ACC_W        = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_REQ  = 120;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_REQS  = 300;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          in_valid   = 1'b0;
    mbp_pkg::t_req in_req     = '0;
    logic          out_stall  = 1'b0;
    logic          in_stall;
    logic          out_valid;
    mbp_pkg::t_rsp out_rsp;

    msb_first_bit_packer #(
        .ACC_BITS (ACC_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    // Shadow of the packer state
    logic [63:0] shadow_acc  = '0;
    int          shadow_fill = 0;
    logic [63:0] shadow_bits = '0;
    logic [7:0]  drained     [0:7];
    int          drained_cnt;

    mbp_pkg::t_req  pending_reqs   [$];
    mbp_pkg::t_rsp  expected_bytes [$];

    logic  req_taken   = 1'b0;
    int    reqs_taken  = 0;
    int    bytes_seen  = 0;
    int    mismatches  = 0;
    int    cycle_count = 0;

    // Sender burst/gap shaping
    int    burst_left = 0;
    int    gap_left   = 0;

    // Receiver stall pattern
    t_stall_mode seg_mode  = STALL_NONE;
    int          seg_left  = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic mbp_pkg::t_req write_req(input logic [63:0] c, input logic [6:0] w);
        mbp_pkg::t_req r;
        r.func  = mbp_pkg::FUNC_WRITE;
        r.code  = c;
        r.width = w;
        return r;
    endfunction

    function automatic mbp_pkg::t_req flush_req(input logic [63:0] c, input logic [6:0] w);
        mbp_pkg::t_req r;
        r.func  = mbp_pkg::FUNC_FLUSH;
        r.code  = c;
        r.width = w;
        return r;
    endfunction

    // Empty the shadow accumulator into drained[], MSB first, last byte zero-padded.
    task automatic drain_shadow();
        int left;
        int take;
        logic [63:0] chunk;
        left = shadow_fill;
        drained_cnt = 0;
        while (left != 0 && drained_cnt < 8) begin
            take  = (left < 8) ? left : 8;
            chunk = (shadow_acc >> (left - take)) & ((64'd1 << take) - 64'd1);
            drained[drained_cnt] = 8'(chunk << (8 - take));
            drained_cnt++;
            left -= take;
        end
        shadow_acc  = '0;
        shadow_fill = 0;
    endtask

    // Apply one accepted request to the shadow state and queue the bytes it emits.
    task automatic pack_request(input mbp_pkg::t_req r);
        int            w;
        int            room;
        int            take;
        logic [63:0]   chunk;
        logic [63:0]   acc_mask;
        logic [63:0]   byte_total;
        mbp_pkg::t_rsp rsp;
        acc_mask    = {64{1'b1}} >> (64 - ACC_W);
        drained_cnt = 0;
        if (r.func == mbp_pkg::FUNC_FLUSH) begin
            drain_shadow();
        end else begin
            w = (r.width > 7'd64) ? 64 : int'(r.width);
            while (w != 0) begin
                // full accumulator only empties once more bits actually arrive
                if (shadow_fill >= ACC_W) begin
                    drain_shadow();
                end
                room = ACC_W - shadow_fill;
                take = (w < room) ? w : room;
                if (take > 8) begin
                    take = 8;
                end
                chunk       = (r.code >> (w - take)) & ((64'd1 << take) - 64'd1);
                shadow_acc  = ((shadow_acc << take) | chunk) & acc_mask;
                shadow_fill += take;
                w           -= take;
                shadow_bits += 64'(take);
            end
        end
        byte_total = (shadow_bits >> 3) + ((shadow_bits[2:0] != 3'd0) ? 64'd1 : 64'd0);
        for (int k = 0; k < drained_cnt; k++) begin
            rsp.out_byte    = drained[k];
            rsp.last        = (k == drained_cnt - 1);
            rsp.total_bits  = shadow_bits;
            rsp.total_bytes = byte_total[61:0];
            expected_bytes.push_back(rsp);
        end
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch on byte %0d: %s", $realtime, bytes_seen, msg);
        end
    endtask

    task automatic check_byte(input mbp_pkg::t_rsp got);
        mbp_pkg::t_rsp want;
        if (expected_bytes.size() == 0) begin
            log_mismatch($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                log_mismatch($sformatf("out_byte exp %02h got %02h",
                                       want.out_byte, got.out_byte));
            end
            if (got.last !== want.last) begin
                log_mismatch($sformatf("last exp %0b got %0b", want.last, got.last));
            end
            if (got.total_bits !== want.total_bits) begin
                log_mismatch($sformatf("total_bits exp %0d got %0d",
                                       want.total_bits, got.total_bits));
            end
            if (got.total_bytes !== want.total_bytes) begin
                log_mismatch($sformatf("total_bytes exp %0d got %0d",
                                       want.total_bytes, got.total_bytes));
            end
        end
        bytes_seen++;
    endtask

    // Monitor: request acceptance feeds the predictor, result bytes get checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                pack_request(in_req);
                reqs_taken <= reqs_taken + 1;
            end
            if (out_valid && !out_stall) begin
                check_byte(out_rsp);
            end
        end
    end

    // Driver: bursts of requests separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                in_req   <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: segments of differing stall density, plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && reqs_taken >= HOLD_AT_REQ) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_mode <= t_stall_mode'($urandom_range(0, 3));
                seg_left <= $urandom_range(10, 80);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                STALL_NONE: begin
                    out_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_HEAVY: begin
                    out_stall <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    out_stall <= (seg_left % 3 == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, expected_bytes.size());
            $display("** msb_first_bit_packer: FAILED **");
            $finish;
        end
    end

    initial begin
        int          pick;
        logic [63:0] rnd_code;

        // Directed requests
        pending_reqs.push_back(write_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd0));  // no-op write
        pending_reqs.push_back(flush_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd64)); // empty flush
        pending_reqs.push_back(write_req(64'h1, 7'd1));
        pending_reqs.push_back(flush_req(64'h0, 7'd0));                    // single padded byte
        pending_reqs.push_back(write_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd64)); // full, nothing out
        pending_reqs.push_back(write_req(64'h0, 7'd0));
        pending_reqs.push_back(flush_req(64'h0, 7'd127));
        pending_reqs.push_back(write_req(64'h0123_4567_89AB_CDEF, 7'd64));
        pending_reqs.push_back(write_req(64'hFFFF_FFFF_FFFF_FFFD, 7'd3));  // drains full acc
        pending_reqs.push_back(flush_req(64'h5555_5555_5555_5555, 7'd5));
        pending_reqs.push_back(write_req(64'hA5A5_5A5A_C3C3_3C3C, 7'd127)); // width saturates
        pending_reqs.push_back(write_req(64'h8000_0000_0000_0001, 7'd65));
        pending_reqs.push_back(flush_req(64'h0, 7'd0));
        pending_reqs.push_back(write_req(64'hFFFF_FFFF_FFFF_FF80, 7'd7));  // high bits ignored
        pending_reqs.push_back(write_req(64'hFEDC_BA98_7654_3210, 7'd60));
        pending_reqs.push_back(write_req(64'h0000_0000_0000_00C3, 7'd8));  // fits without a drain
        pending_reqs.push_back(flush_req(64'h0, 7'd0));
        pending_reqs.push_back(write_req(64'h0, 7'd64));
        pending_reqs.push_back(write_req(64'h7F, 7'd7));
        pending_reqs.push_back(write_req(64'h0, 7'd1));
        pending_reqs.push_back(flush_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd64));

        // Random requests, mostly short codes so bursts come often
        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick     = $urandom_range(0, 99);
            rnd_code = {$urandom, $urandom};
            if (pick < 8) begin
                pending_reqs.push_back(flush_req(rnd_code, 7'($urandom_range(0, 127))));
            end else if (pick < 12) begin
                pending_reqs.push_back(write_req(rnd_code, 7'd0));
            end else if (pick < 18) begin
                pending_reqs.push_back(write_req(rnd_code, 7'($urandom_range(65, 127))));
            end else if (pick < 35) begin
                pending_reqs.push_back(write_req(rnd_code, 7'($urandom_range(17, 64))));
            end else begin
                pending_reqs.push_back(write_req(rnd_code, 7'($urandom_range(1, 16))));
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("** msb_first_bit_packer: PASSED **");
        end else begin
            $display("** msb_first_bit_packer: FAILED **");
        end
        $finish;
    end

endmodule
